/* design/lbf_pkg.sv */
// Shared types, codes and arithmetic helpers for the LED blink/fade controller.
package lbf_pkg;

  localparam int TIMER_BITS = 24;
  localparam int DUR_W      = 24;
  localparam int CNT_W      = 16;
  localparam int LEVEL_W    = 8;
  localparam int PCT_W      = 7;
  localparam int CFG_W      = 24;
  localparam int REG_IDX_W  = 3;
  localparam int CMP_W      = (TIMER_BITS > DUR_W) ? TIMER_BITS : DUR_W;
  localparam int DIV_W      = CMP_W + PCT_W;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = '1;
  localparam logic [LEVEL_W-1:0] LEVEL_OFF  = '0;
  localparam logic [PCT_W-1:0]   PCT_FULL   = PCT_W'(100);

  // operation codes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_SET    = 2'd2;
  localparam logic [1:0] OP_TOGGLE = 2'd3;

  // fade phases
  localparam logic [1:0] PH_RISE = 2'd0;
  localparam logic [1:0] PH_ON   = 2'd1;
  localparam logic [1:0] PH_FALL = 2'd2;
  localparam logic [1:0] PH_OFF  = 2'd3;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_RISE_TIME      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ON_TIME        = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FALL_TIME      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DARK_TIME      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_REPEAT_COUNT   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_REPEAT_FOREVER = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_MODE   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_ACTIVE_LOW     = 3'd7;

  typedef struct packed {
    logic [1:0]         operation;
    logic [LEVEL_W-1:0] level;
  } cmd_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] pwm_duty;
    logic [LEVEL_W-1:0] brightness;
    logic               pattern_running;
    logic [1:0]         fade_phase;
  } res_t;

  typedef struct packed {
    logic                  start;
    logic [TIMER_BITS-1:0] elapsed;
    logic [DUR_W-1:0]      duration;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] pct;
  } div_resp_t;

  // floor(pct*255/100) for pct <= 100; divide by 100 as multiply by 5243 >> 19
  function automatic logic [LEVEL_W-1:0] pct_level(input logic [PCT_W-1:0] pct);
    logic [14:0] scaled;
    logic [27:0] prod;
    scaled = {pct, 8'b0} - 15'(pct);
    prod   = 28'(scaled) * 28'd5243;
    return prod[26:19];
  endfunction

endpackage

/* design/lbf_pct_div.sv */
// Serial restoring divider: pct = floor(elapsed*100/duration), one quotient bit a cycle.
module lbf_pct_div (
  input  logic                clk,
  input  logic                rst,
  input  lbf_pkg::div_req_t   req,
  output lbf_pkg::div_resp_t  resp
);

  logic [lbf_pkg::DIV_W-1:0] rem;
  logic [lbf_pkg::DIV_W-1:0] den;
  logic [lbf_pkg::PCT_W-2:0] quo;
  logic [2:0]                cnt;
  logic                      busy;
  logic [lbf_pkg::DIV_W-1:0] dividend;
  logic                      ge;

  assign dividend = (lbf_pkg::DIV_W'(req.elapsed) << 6) + (lbf_pkg::DIV_W'(req.elapsed) << 5)
                  + (lbf_pkg::DIV_W'(req.elapsed) << 2);
  assign ge = (rem >= den);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= 3'(lbf_pkg::PCT_W - 1);
    end else if (busy) begin
      cnt <= cnt - 3'd1;
      if (cnt == 3'd0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= dividend;
      den <= lbf_pkg::DIV_W'(req.duration) << (lbf_pkg::PCT_W - 1);
      quo <= '0;
    end else if (busy) begin
      // subtract when the shifted divisor fits, then move to the next bit
      if (ge) begin
        rem <= rem - den;
      end
      den <= den >> 1;
      quo <= {quo[lbf_pkg::PCT_W-3:0], ge};
    end
  end

  assign resp = {busy && (cnt == 3'd0), quo, ge};

endmodule

/* design/led_blink_fade_controller_core.sv */
// Top level of the LED blink/fade controller: sequencer, pattern state and result register.
//
//  channel  | valid      | stall      | payload
//  ---------+------------+------------+------------------------------------------
//  cmd      | cmd_valid  | cmd_stall  | cmd (operation, level)
//  res      | res_valid  | res_stall  | res (pwm_duty, brightness, running, phase)
//  cfg      | cfg_write  | -          | cfg_index, cfg_data
//
// A tick that lands on a fade ramp runs through the serial percent divider, whose last cycle
// also maps percent to level, and then has its result loaded. Every other item goes straight
// to the result state and has its result loaded there.
// One item is in work at a time; cmd_stall is high until its result is loaded, which waits
// while a previous result sits stalled; at best the next item is taken in the next cycle.
// Reset (rst, synchronous) clears configuration, control and pattern state, not the result
module led_blink_fade_controller_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_stall,
  input  lbf_pkg::cmd_t                     cmd,
  output logic                              res_valid,
  input  logic                              res_stall,
  output lbf_pkg::res_t                     res,
  input  logic                              cfg_write,
  input  logic [lbf_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [lbf_pkg::CFG_W-1:0]         cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_RES  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [lbf_pkg::DUR_W-1:0]   rise_time;
  logic [lbf_pkg::DUR_W-1:0]   on_time;
  logic [lbf_pkg::DUR_W-1:0]   fall_time;
  logic [lbf_pkg::DUR_W-1:0]   dark_time;
  logic [lbf_pkg::CNT_W-1:0]   repeat_count;
  logic                        repeat_forever;
  logic                        pattern_mode;
  logic                        active_low;

  logic [lbf_pkg::LEVEL_W-1:0]    level_now;
  logic [lbf_pkg::LEVEL_W-1:0]    level_now_next;
  logic [1:0]                     phase_now;
  logic [1:0]                     phase_now_next;
  logic                           blinking;
  logic                           blinking_next;
  logic                           fading;
  logic                           fading_next;
  logic [lbf_pkg::CNT_W-1:0]      cycles_left;
  logic [lbf_pkg::CNT_W-1:0]      cycles_left_next;
  logic [lbf_pkg::TIMER_BITS-1:0] elapsed;
  logic [lbf_pkg::TIMER_BITS-1:0] elapsed_next;
  logic                           fall_sel;

  logic                           cmd_fire;
  logic                           load_res;
  logic [lbf_pkg::TIMER_BITS-1:0] el_inc;
  logic [lbf_pkg::CMP_W-1:0]      el_cmp;
  logic [lbf_pkg::CNT_W-1:0]      cl_dec;
  logic                           ramp_go;
  logic                           ramp_fall;
  logic [lbf_pkg::PCT_W-1:0]      ramp_pct;
  logic [lbf_pkg::LEVEL_W-1:0]    ramp_level;

  lbf_pkg::div_req_t  div_req;
  lbf_pkg::div_resp_t div_resp;

  assign cmd_stall = (state != S_IDLE);
  assign cmd_fire  = cmd_valid && !cmd_stall;
  assign load_res  = (state == S_RES) && (!res_valid || !res_stall);

  // saturating tick count
  assign el_inc = (elapsed == '1) ? elapsed : elapsed + 1'b1;
  assign el_cmp = lbf_pkg::CMP_W'(el_inc);
  assign cl_dec = (cycles_left != '0) ? cycles_left - 1'b1 : cycles_left;

  assign ramp_pct   = fall_sel ? (lbf_pkg::PCT_FULL - div_resp.pct) : div_resp.pct;
  assign ramp_level = lbf_pkg::pct_level(ramp_pct);

  assign div_req = {ramp_go, el_inc, (ramp_fall ? fall_time : rise_time)};

  lbf_pct_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .resp (div_resp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_time      <= '0;
      on_time        <= '0;
      fall_time      <= '0;
      dark_time      <= '0;
      repeat_count   <= '0;
      repeat_forever <= 1'b0;
      pattern_mode   <= 1'b0;
      active_low     <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        lbf_pkg::REG_RISE_TIME:      rise_time      <= cfg_data[lbf_pkg::DUR_W-1:0];
        lbf_pkg::REG_ON_TIME:        on_time        <= cfg_data[lbf_pkg::DUR_W-1:0];
        lbf_pkg::REG_FALL_TIME:      fall_time      <= cfg_data[lbf_pkg::DUR_W-1:0];
        lbf_pkg::REG_DARK_TIME:      dark_time      <= cfg_data[lbf_pkg::DUR_W-1:0];
        lbf_pkg::REG_REPEAT_COUNT:   repeat_count   <= cfg_data[lbf_pkg::CNT_W-1:0];
        lbf_pkg::REG_REPEAT_FOREVER: repeat_forever <= cfg_data[0];
        lbf_pkg::REG_PATTERN_MODE:   pattern_mode   <= cfg_data[0];
        lbf_pkg::REG_ACTIVE_LOW:     active_low     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    level_now_next   = level_now;
    phase_now_next   = phase_now;
    blinking_next    = blinking;
    fading_next      = fading;
    cycles_left_next = cycles_left;
    elapsed_next     = elapsed;
    ramp_go          = 1'b0;
    ramp_fall        = 1'b0;
    if (cmd_fire) begin
      case (cmd.operation)
        lbf_pkg::OP_TICK: begin
          elapsed_next = el_inc;
          if (blinking) begin
            if (level_now == lbf_pkg::LEVEL_FULL &&
                el_cmp >= lbf_pkg::CMP_W'(on_time)) begin
              level_now_next = lbf_pkg::LEVEL_OFF;
              elapsed_next   = '0;
              if (!repeat_forever) begin
                cycles_left_next = cl_dec;
                if (cl_dec == '0) begin
                  blinking_next = 1'b0;
                end
              end
            end else if (level_now == lbf_pkg::LEVEL_OFF &&
                         el_cmp >= lbf_pkg::CMP_W'(dark_time)) begin
              level_now_next = lbf_pkg::LEVEL_FULL;
              elapsed_next   = '0;
            end else if (level_now != lbf_pkg::LEVEL_OFF &&
                         level_now != lbf_pkg::LEVEL_FULL) begin
              level_now_next = lbf_pkg::LEVEL_FULL;
              elapsed_next   = '0;
            end
          end
          if (fading) begin
            case (phase_now)
              lbf_pkg::PH_RISE: begin
                if (el_cmp < lbf_pkg::CMP_W'(rise_time)) begin
                  ramp_go = 1'b1;
                end else begin
                  elapsed_next   = '0;
                  phase_now_next = lbf_pkg::PH_ON;
                end
              end
              lbf_pkg::PH_ON: begin
                if (el_cmp < lbf_pkg::CMP_W'(on_time)) begin
                  level_now_next = lbf_pkg::LEVEL_FULL;
                end else begin
                  elapsed_next   = '0;
                  phase_now_next = lbf_pkg::PH_FALL;
                end
              end
              lbf_pkg::PH_FALL: begin
                if (el_cmp < lbf_pkg::CMP_W'(fall_time)) begin
                  ramp_go   = 1'b1;
                  ramp_fall = 1'b1;
                end else begin
                  elapsed_next   = '0;
                  phase_now_next = lbf_pkg::PH_OFF;
                end
              end
              default: begin
                if (el_cmp < lbf_pkg::CMP_W'(dark_time)) begin
                  level_now_next = lbf_pkg::LEVEL_OFF;
                end else begin
                  if (!repeat_forever) begin
                    cycles_left_next = cl_dec;
                  end
                  if (!repeat_forever && cl_dec == '0) begin
                    fading_next = 1'b0;
                  end else begin
                    elapsed_next   = '0;
                    phase_now_next = lbf_pkg::PH_RISE;
                  end
                end
              end
            endcase
          end
        end
        lbf_pkg::OP_START: begin
          blinking_next    = 1'b0;
          fading_next      = 1'b0;
          cycles_left_next = repeat_count;
          if (repeat_count != '0 || repeat_forever) begin
            if (pattern_mode) begin
              elapsed_next   = '0;
              phase_now_next = lbf_pkg::PH_RISE;
              fading_next    = 1'b1;
            end else begin
              // blink starts with the current phase already expired
              elapsed_next  = '1;
              blinking_next = 1'b1;
            end
          end
        end
        lbf_pkg::OP_SET: begin
          blinking_next  = 1'b0;
          fading_next    = 1'b0;
          level_now_next = cmd.level;
        end
        default: begin
          blinking_next  = 1'b0;
          fading_next    = 1'b0;
          level_now_next = lbf_pkg::LEVEL_FULL - level_now;
        end
      endcase
    end else if (state == S_DIV && div_resp.done) begin
      level_now_next = ramp_level;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_fire) begin
          state_next = ramp_go ? S_DIV : S_RES;
        end
      end
      S_DIV: begin
        if (div_resp.done) begin
          state_next = S_RES;
        end
      end
      S_RES: begin
        if (load_res) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      level_now   <= '0;
      phase_now   <= lbf_pkg::PH_RISE;
      blinking    <= 1'b0;
      fading      <= 1'b0;
      cycles_left <= '0;
      elapsed     <= '0;
      res_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      level_now   <= level_now_next;
      phase_now   <= phase_now_next;
      blinking    <= blinking_next;
      fading      <= fading_next;
      cycles_left <= cycles_left_next;
      elapsed     <= elapsed_next;
      if (load_res) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      fall_sel <= ramp_fall;
    end
    if (load_res) begin
      res.pwm_duty        <= active_low ? (lbf_pkg::LEVEL_FULL - level_now) : level_now;
      res.brightness      <= level_now;
      res.pattern_running <= blinking || fading;
      res.fade_phase      <= phase_now;
    end
  end

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_resp.done |-> (state == S_DIV))
    else $error("divider finished outside the divide state");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    div_resp.done |-> (div_resp.pct < lbf_pkg::PCT_FULL))
    else $error("ramp percent out of range");

  a_one_pattern: assert property (@(posedge clk) disable iff (rst)
    !(blinking && fading))
    else $error("blink and fade active together");

  a_set_stops: assert property (@(posedge clk) disable iff (rst)
    (cmd_fire && (cmd.operation == lbf_pkg::OP_SET || cmd.operation == lbf_pkg::OP_TOGGLE))
    |=> !(blinking || fading))
    else $error("set or toggle left a pattern running");

endmodule

/* tb/led_blink_fade_controller_core_tb.sv */
// Self-checking testbench for the LED blink/fade controller core.
module led_blink_fade_controller_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 5000;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 75;
  localparam logic [lbf_pkg::TIMER_BITS-1:0] TICK_MAX = '1;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          cmd_valid = 1'b0;
  logic                          cmd_stall;
  lbf_pkg::cmd_t                 cmd = '0;
  logic                          res_valid;
  logic                          res_stall = 1'b0;
  lbf_pkg::res_t                 res;
  logic                          cfg_write = 1'b0;
  logic [lbf_pkg::REG_IDX_W-1:0] cfg_index = '0;
  logic [lbf_pkg::CFG_W-1:0]     cfg_data = '0;

  led_blink_fade_controller_core DUT (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow configuration
  logic [lbf_pkg::DUR_W-1:0] rise_t = '0, hold_on_t = '0, fall_t = '0, hold_off_t = '0;
  logic [lbf_pkg::CNT_W-1:0] cycle_count = '0;
  logic                      endless = 1'b0, fade_sel = 1'b0, invert_out = 1'b0;

  // shadow LED state
  logic [lbf_pkg::LEVEL_W-1:0]    led_level = '0;
  logic [1:0]                     led_phase = lbf_pkg::PH_RISE;
  logic                           blink_on = 1'b0, fade_on = 1'b0;
  logic [lbf_pkg::CNT_W-1:0]      cycles_rem = '0;
  logic [lbf_pkg::TIMER_BITS-1:0] tick_cnt = '0;

  lbf_pkg::res_t pending_led_reports[$];
  lbf_pkg::res_t oldest_report;

  int unsigned send_gap_max = 14;
  int unsigned drain_gap_max = 14;
  int unsigned items_sent = 0;
  int unsigned reports_checked = 0;
  int unsigned report_mismatches = 0;
  int unsigned config_loads = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [lbf_pkg::LEVEL_W-1:0] ramp_brightness(
      input logic [lbf_pkg::TIMER_BITS-1:0] el,
      input logic [lbf_pkg::DUR_W-1:0] dur,
      input logic falling);
    logic [63:0] pct;
    pct = (dur == '0) ? 64'd0 : (64'(el) * 64'd100) / 64'(dur);
    if (pct > 64'd100) pct = 64'd100;
    if (falling) pct = 64'd100 - pct;
    return lbf_pkg::LEVEL_W'((pct * 64'd255) / 64'd100);
  endfunction

  // Advance the shadow LED by one item and form the report it produces.
  task automatic apply_led_item(input lbf_pkg::cmd_t c, output lbf_pkg::res_t r);
    case (c.operation)
      lbf_pkg::OP_TICK: begin
        if (tick_cnt != TICK_MAX) tick_cnt = tick_cnt + 1'b1;
        if (blink_on) begin
          if (led_level == lbf_pkg::LEVEL_FULL && tick_cnt >= hold_on_t) begin
            led_level = lbf_pkg::LEVEL_OFF;
            tick_cnt = '0;
            if (!endless) begin
              if (cycles_rem != 0) cycles_rem = cycles_rem - 1'b1;
              if (cycles_rem == 0) blink_on = 1'b0;
            end
          end else if (led_level == lbf_pkg::LEVEL_OFF && tick_cnt >= hold_off_t) begin
            led_level = lbf_pkg::LEVEL_FULL;
            tick_cnt = '0;
          end else if (led_level != lbf_pkg::LEVEL_OFF &&
                       led_level != lbf_pkg::LEVEL_FULL) begin
            led_level = lbf_pkg::LEVEL_FULL;
            tick_cnt = '0;
          end
        end
        if (fade_on) begin
          case (led_phase)
            lbf_pkg::PH_RISE: begin
              if (tick_cnt < rise_t) led_level = ramp_brightness(tick_cnt, rise_t, 1'b0);
              else begin
                tick_cnt = '0;
                led_phase = lbf_pkg::PH_ON;
              end
            end
            lbf_pkg::PH_ON: begin
              if (tick_cnt < hold_on_t) led_level = lbf_pkg::LEVEL_FULL;
              else begin
                tick_cnt = '0;
                led_phase = lbf_pkg::PH_FALL;
              end
            end
            lbf_pkg::PH_FALL: begin
              if (tick_cnt < fall_t) led_level = ramp_brightness(tick_cnt, fall_t, 1'b1);
              else begin
                tick_cnt = '0;
                led_phase = lbf_pkg::PH_OFF;
              end
            end
            default: begin
              if (tick_cnt < hold_off_t) led_level = lbf_pkg::LEVEL_OFF;
              else begin
                if (!endless && cycles_rem != 0) cycles_rem = cycles_rem - 1'b1;
                if (!endless && cycles_rem == 0) fade_on = 1'b0;
                else begin
                  tick_cnt = '0;
                  led_phase = lbf_pkg::PH_RISE;
                end
              end
            end
          endcase
        end
      end
      lbf_pkg::OP_START: begin
        blink_on = 1'b0;
        fade_on = 1'b0;
        cycles_rem = cycle_count;
        if (cycles_rem != 0 || endless) begin
          if (fade_sel) begin
            tick_cnt = '0;
            led_phase = lbf_pkg::PH_RISE;
            fade_on = 1'b1;
          end else begin
            // blink starts with its phase time already used up
            tick_cnt = TICK_MAX;
            blink_on = 1'b1;
          end
        end
      end
      lbf_pkg::OP_SET: begin
        blink_on = 1'b0;
        fade_on = 1'b0;
        led_level = c.level;
      end
      default: begin
        blink_on = 1'b0;
        fade_on = 1'b0;
        led_level = ~led_level;
      end
    endcase
    r.pwm_duty = invert_out ? ~led_level : led_level;
    r.brightness = led_level;
    r.pattern_running = blink_on | fade_on;
    r.fade_phase = led_phase;
  endtask

  task automatic send_item(input logic [1:0] op, input logic [lbf_pkg::LEVEL_W-1:0] lv);
    int unsigned gap;
    lbf_pkg::cmd_t c;
    lbf_pkg::res_t r;
    gap = $urandom_range(0, send_gap_max);
    c.operation = op;
    c.level = lv;
    @(negedge clk);
    if (gap != 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (cmd_stall);
    apply_led_item(c, r);
    pending_led_reports.push_back(r);
    items_sent++;
  endtask

  // Drop valid and let every outstanding report drain.
  task automatic drain_reports();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (pending_led_reports.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [lbf_pkg::REG_IDX_W-1:0] idx,
                           input logic [lbf_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      lbf_pkg::REG_RISE_TIME:      rise_t = data[lbf_pkg::DUR_W-1:0];
      lbf_pkg::REG_ON_TIME:        hold_on_t = data[lbf_pkg::DUR_W-1:0];
      lbf_pkg::REG_FALL_TIME:      fall_t = data[lbf_pkg::DUR_W-1:0];
      lbf_pkg::REG_DARK_TIME:      hold_off_t = data[lbf_pkg::DUR_W-1:0];
      lbf_pkg::REG_REPEAT_COUNT:   cycle_count = data[lbf_pkg::CNT_W-1:0];
      lbf_pkg::REG_REPEAT_FOREVER: endless = data[0];
      lbf_pkg::REG_PATTERN_MODE:   fade_sel = data[0];
      default:                     invert_out = data[0];
    endcase
  endtask

  // Write all eight registers; unused upper data bits sometimes carry junk.
  task automatic load_config(input logic [lbf_pkg::DUR_W-1:0] rise,
                             input logic [lbf_pkg::DUR_W-1:0] on_d,
                             input logic [lbf_pkg::DUR_W-1:0] fall,
                             input logic [lbf_pkg::DUR_W-1:0] off_d,
                             input logic [lbf_pkg::CNT_W-1:0] count, input logic endless_v,
                             input logic fade_v, input logic invert_v);
    logic [lbf_pkg::CFG_W-1:0] junk;
    junk = ($urandom_range(0, 1) != 0) ? lbf_pkg::CFG_W'($urandom) : '0;
    write_reg(lbf_pkg::REG_RISE_TIME, rise);
    write_reg(lbf_pkg::REG_ON_TIME, on_d);
    write_reg(lbf_pkg::REG_FALL_TIME, fall);
    write_reg(lbf_pkg::REG_DARK_TIME, off_d);
    write_reg(lbf_pkg::REG_REPEAT_COUNT, {junk[lbf_pkg::CFG_W-1:lbf_pkg::CNT_W], count});
    write_reg(lbf_pkg::REG_REPEAT_FOREVER, {junk[lbf_pkg::CFG_W-1:1], endless_v});
    write_reg(lbf_pkg::REG_PATTERN_MODE, {junk[lbf_pkg::CFG_W-1:1], fade_v});
    write_reg(lbf_pkg::REG_ACTIVE_LOW, {junk[lbf_pkg::CFG_W-1:1], invert_v});
    @(negedge clk);
    cfg_write <= 1'b0;
    config_loads++;
  endtask

  task automatic test_commands();
    load_config(24'd4, 24'd2, 24'd4, 24'd1, 16'd1, 1'b0, 1'b0, 1'b0);
    send_item(lbf_pkg::OP_TICK, 8'hC3);
    send_item(lbf_pkg::OP_SET, 8'h00);
    send_item(lbf_pkg::OP_SET, 8'hFF);
    send_item(lbf_pkg::OP_SET, 8'hA5);
    send_item(lbf_pkg::OP_TOGGLE, 8'h00);
    send_item(lbf_pkg::OP_TOGGLE, 8'hFF);
  endtask

  // Start from a middle level: the first tick must go full on.
  task automatic test_blink();
    drain_reports();
    load_config(24'd4, 24'd2, 24'd4, 24'd1, 16'd2, 1'b1, 1'b0, 1'b0);
    send_item(lbf_pkg::OP_SET, 8'h5A);
    send_item(lbf_pkg::OP_START, 8'h00);
    repeat (4) send_item(lbf_pkg::OP_TICK, 8'h00);
  endtask

  // A start with nothing to run stops the blink left running above.
  task automatic test_zero_count();
    drain_reports();
    load_config(24'd4, 24'd2, 24'd4, 24'd1, 16'd0, 1'b0, 1'b0, 1'b0);
    send_item(lbf_pkg::OP_START, 8'hFF);
    send_item(lbf_pkg::OP_TICK, 8'h00);
  endtask

  task automatic test_fade();
    drain_reports();
    load_config(24'd2, 24'd0, 24'd2, 24'd0, 16'd1, 1'b0, 1'b1, 1'b1);
    send_item(lbf_pkg::OP_START, 8'h00);
    repeat (6) send_item(lbf_pkg::OP_TICK, 8'h00);
  endtask

  // Full-scale phase times: the saturated start still expires, later phases hold.
  task automatic test_long_durations();
    drain_reports();
    load_config('1, '1, '1, '1, '1, 1'b0, 1'b0, 1'b0);
    send_item(lbf_pkg::OP_SET, 8'h00);
    send_item(lbf_pkg::OP_START, 8'h00);
    send_item(lbf_pkg::OP_TICK, 8'h00);
    send_item(lbf_pkg::OP_TICK, 8'h00);
  endtask

  function automatic logic [lbf_pkg::DUR_W-1:0] pick_duration();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 14) return lbf_pkg::DUR_W'($urandom_range(0, 8));
    if (sel < 17) return lbf_pkg::DUR_W'($urandom_range(9, 60));
    if (sel == 17) return '0;
    if (sel == 18) return '1;
    return lbf_pkg::DUR_W'($urandom);
  endfunction

  function automatic logic [lbf_pkg::CNT_W-1:0] pick_count();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return lbf_pkg::CNT_W'($urandom_range(1, 4));
    if (sel == 6) return '0;
    if (sel == 7) return '1;
    return lbf_pkg::CNT_W'($urandom);
  endfunction

  task automatic test_random();
    int unsigned pick;
    logic [lbf_pkg::LEVEL_W-1:0] lv;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_reports();
      send_gap_max = (ph % 3 == 0) ? 0 : 14;
      drain_gap_max = (ph % 4 == 1) ? 0 : 14;
      if (ph == 0) load_config('0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0);
      else if (ph == 1) load_config('1, '1, '1, '1, '1, 1'b1, 1'b1, 1'b1);
      else
        load_config(pick_duration(), pick_duration(), pick_duration(), pick_duration(),
                    pick_count(), ($urandom_range(0, 3) == 0), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 4))
          0: lv = lbf_pkg::LEVEL_OFF;
          1: lv = lbf_pkg::LEVEL_FULL;
          default: lv = lbf_pkg::LEVEL_W'($urandom);
        endcase
        if (pick < 72) send_item(lbf_pkg::OP_TICK, lv);
        else if (pick < 82) send_item(lbf_pkg::OP_START, lv);
        else if (pick < 91) send_item(lbf_pkg::OP_SET, lv);
        else send_item(lbf_pkg::OP_TOGGLE, lv);
      end
    end
  endtask

  // Result side: random stall before each report, stretches with none.
  initial begin
    int unsigned gap;
    forever begin
      @(negedge clk);
      gap = $urandom_range(0, drain_gap_max);
      if (gap != 0) begin
        res_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      res_stall <= 1'b0;
      do @(posedge clk); while (!(res_valid && !res_stall));
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (pending_led_reports.size() == 0) begin
        if (report_mismatches < 10)
          $display("%0t: unexpected report duty=%0d level=%0d run=%0b phase=%0d",
                   $realtime, res.pwm_duty, res.brightness, res.pattern_running,
                   res.fade_phase);
        report_mismatches++;
      end else begin
        oldest_report = pending_led_reports.pop_front();
        reports_checked++;
        if (res.pwm_duty !== oldest_report.pwm_duty ||
            res.brightness !== oldest_report.brightness ||
            res.pattern_running !== oldest_report.pattern_running ||
            res.fade_phase !== oldest_report.fade_phase) begin
          if (report_mismatches < 10)
            $display("%0t: item %0d exp/got duty %0d/%0d lvl %0d/%0d run %0b/%0b ph %0d/%0d",
                     $realtime, reports_checked, oldest_report.pwm_duty, res.pwm_duty,
                     oldest_report.brightness, res.brightness,
                     oldest_report.pattern_running, res.pattern_running,
                     oldest_report.fade_phase, res.fade_phase);
          report_mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) quiet_cycles <= 0;
    else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no handshake for %0d cycles, %0d reports outstanding",
                 QUIET_LIMIT, pending_led_reports.size());
        $display("led_blink_fade_controller_core test failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_commands();
    test_blink();
    test_zero_count();
    test_fade();
    test_long_durations();
    test_random();
    drain_reports();
    repeat (20) @(posedge clk);
    $display("run covered %0d items over %0d register settings (blink, fade, set, toggle)",
             items_sent, config_loads);
    $display("%0d reports checked, %0d mismatches, %0d reports missing",
             reports_checked, report_mismatches, pending_led_reports.size());
    if (report_mismatches == 0 && pending_led_reports.size() == 0)
      $display("led_blink_fade_controller_core test passed");
    else
      $display("led_blink_fade_controller_core test failed");
    $finish;
  end

endmodule
